### design/kt_pkg.sv
`default_nettype none
package kt_pkg;

	// Width of the running byte position; it wraps at this width.
	localparam int POS_BITS = 16;
	localparam int LEN_BITS = 16;
	localparam int KIND_BITS = 5;

	localparam logic [KIND_BITS-1:0] KIND_END    = 5'd0;
	localparam logic [KIND_BITS-1:0] KIND_IDENT  = 5'd1;
	localparam logic [KIND_BITS-1:0] KIND_NUMBER = 5'd2;
	localparam logic [KIND_BITS-1:0] KIND_STRING = 5'd3;
	localparam logic [KIND_BITS-1:0] KIND_KW0    = 5'd4;
	localparam logic [KIND_BITS-1:0] KIND_SYM0   = 5'd20;

	localparam logic [7:0] CHAR_NUL   = 8'h00;
	localparam logic [7:0] CHAR_QUOTE = 8'h22;

	localparam int KW_COUNT = 16;
	localparam int KW_MAX = 8;
	localparam int SYM_COUNT = 8;

	localparam int QUEUE_DEPTH = 4;

	localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX] = '{
		'{"l", "e", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "p", "r", "i", "n", "t", 8'h00, 8'h00},
		'{"a", "d", "d", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"s", "u", "b", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"m", "u", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"d", "i", "v", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "l", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"e", "q", "u", "a", "l", "s", 8'h00, 8'h00},
		'{"s", "t", "r", "i", "n", "g", 8'h00, 8'h00},
		'{"i", "n", "p", "u", "t", 8'h00, 8'h00, 8'h00},
		'{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "a", "l", "s", "e", 8'h00, 8'h00, 8'h00},
		'{"b", "o", "o", "l", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "u", "n", "c", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "e", "n", "d", 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] KW_LEN [KW_COUNT] = '{
		4'd3, 4'd6, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2, 4'd4,
		4'd6, 4'd6, 4'd5, 4'd4, 4'd5, 4'd4, 4'd4, 4'd4
	};

	localparam logic [7:0] SYM_CHAR [SYM_COUNT] = '{"=", "(", ")", "{", "}", ";", "!", ":"};

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_IDENT  = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_STRING = 2'd3
	} mode_t;

	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [15:0]          start;
		logic [LEN_BITS-1:0]  length;
	} token_t;

	// One queue entry holds the tokens caused by one byte, first one in tok0.
	typedef struct packed {
		logic   two;
		token_t tok0;
		token_t tok1;
	} entry_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || (c >= 8'd9 && c <= 8'd13);
	endfunction

	// Keywords that still agree with the identifier after character c at offset idx.
	function automatic logic [KW_COUNT-1:0] kw_keep(input logic [7:0] c,
		input logic [LEN_BITS-1:0] idx);
		logic [KW_COUNT-1:0] keep;
		keep = '0;
		for (int k = 0; k < KW_COUNT; k++) begin
			keep[k] = (idx < LEN_BITS'(KW_LEN[k])) &&
				(KW_TEXT[k][idx[$clog2(KW_MAX)-1:0]] == c);
		end
		return keep;
	endfunction

	// The earliest keyword still matching at the full length wins.
	function automatic logic [KIND_BITS-1:0] ident_kind(input logic [KW_COUNT-1:0] mask,
		input logic [LEN_BITS-1:0] len);
		logic [KIND_BITS-1:0] kind;
		kind = KIND_IDENT;
		for (int k = KW_COUNT - 1; k >= 0; k--) begin
			if (mask[k] && len == LEN_BITS'(KW_LEN[k])) begin
				kind = KIND_KW0 + KIND_BITS'(k);
			end
		end
		return kind;
	endfunction

endpackage
`default_nettype wire

### design/kt_byte_if.sv
`default_nettype none
interface kt_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;

	modport source(output valid, output text_byte, input ready);
	modport sink(input valid, input text_byte, output ready);
endinterface
`default_nettype wire

### design/kt_token_if.sv
`default_nettype none
interface kt_token_if;
	logic        valid;
	logic        ready;
	logic [4:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_item;

	modport source(output valid, output token_kind, output token_start,
		output token_length, output last_of_item, input ready);
	modport sink(input valid, input token_kind, input token_start,
		input token_length, input last_of_item, output ready);
endinterface
`default_nettype wire

### design/keyword_tokenizer.sv
// Path: a byte's tokens are written into the queue at that byte's transfer; with the queue
// and the output register empty, the first one is then loaded into the output register.
// Throughput: one byte per cycle while the queue has room; the output register sends one
// token per cycle when not stalled, so a byte's two tokens go out one after the other.
// Reset: arst_n asynchronously returns the scanner to idle at position zero and empties
// the token queue; there is no clearing pass and the block accepts bytes right away.
`default_nettype none
module keyword_tokenizer import kt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	kt_byte_if.sink    text,
	kt_token_if.source token
);

	// The front end runs the scanner: one byte per transfer updates the mode, the
	// pending token, and the keyword match mask, and produces the zero, one or two
	// tokens that byte causes as a single queue entry.
	logic   push_valid, push_ready;
	entry_t push_entry;

	// The queue lets the scanner keep taking bytes while the output side stalls;
	// when it fills, the byte channel's ready drops.
	logic   pop, head_valid;
	entry_t head_entry;

	kt_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready)
	);

	kt_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_entry (push_entry),
		.push_ready (push_ready),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	// The back end splits an entry into single token transfers and marks the last
	// token of each byte with last_of_item.
	kt_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.token      (token)
	);

endmodule
`default_nettype wire

### design/kt_front.sv
`default_nettype none
module kt_front import kt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	kt_byte_if.sink text,
	output logic   push_valid,
	output entry_t push_entry,
	input  logic   push_ready
);

	mode_t                mode_q, mode_d;
	logic [POS_BITS-1:0]  pos_q, pos_d;
	logic [15:0]          start_q, start_d;
	logic [LEN_BITS-1:0]  len_q, len_d;
	logic [KW_COUNT-1:0]  mask_q, mask_d;

	logic [7:0]           c;
	logic                 acc;
	logic [31:0]          pos_w, pos_inc_w;
	logic [POS_BITS-1:0]  pos_inc;
	logic [15:0]          pos16, pos_inc16;
	logic [LEN_BITS-1:0]  len_grow;
	logic                 alnum;

	logic                 idle_emit;
	token_t               idle_tok;
	mode_t                idle_mode;
	logic [15:0]          idle_start;
	logic [LEN_BITS-1:0]  idle_len;
	logic [KW_COUNT-1:0]  idle_mask;

	token_t               tok0, tok1;
	logic [1:0]           n_tok;

	assign c = text.text_byte;
	assign text.ready = push_ready;
	assign acc = text.valid && text.ready;

	assign pos_inc   = pos_q + POS_BITS'(1);
	assign pos_w     = 32'(pos_q);
	assign pos_inc_w = 32'(pos_inc);
	assign pos16     = pos_w[15:0];
	assign pos_inc16 = pos_inc_w[15:0];
	assign len_grow  = (len_q == '1) ? len_q : len_q + LEN_BITS'(1);
	assign alnum     = is_letter(c) || is_digit(c);

	// What a byte does when no token is open.
	always_comb begin
		idle_emit  = 1'b0;
		idle_tok   = '{kind: KIND_END, start: pos16, length: '0};
		idle_mode  = MODE_IDLE;
		idle_start = start_q;
		idle_len   = len_q;
		idle_mask  = mask_q;
		if (c == CHAR_NUL) begin
			idle_emit = 1'b1;
		end else if (is_space(c)) begin
			idle_emit = 1'b0;
		end else if (is_letter(c)) begin
			idle_mode  = MODE_IDENT;
			idle_start = pos16;
			idle_len   = LEN_BITS'(1);
			idle_mask  = kw_keep(c, '0);
		end else if (is_digit(c)) begin
			idle_mode  = MODE_NUMBER;
			idle_start = pos16;
			idle_len   = LEN_BITS'(1);
		end else if (c == CHAR_QUOTE) begin
			idle_mode  = MODE_STRING;
			idle_start = pos_inc16;
			idle_len   = '0;
		end else begin
			idle_emit = 1'b1;
			for (int s = 0; s < SYM_COUNT; s++) begin
				if (SYM_CHAR[s] == c) begin
					idle_tok.kind   = KIND_SYM0 + KIND_BITS'(s);
					idle_tok.length = LEN_BITS'(1);
				end
			end
		end
	end

	// Next scan mode.
	always_comb begin
		case (mode_q)
			MODE_IDENT:  mode_d = alnum ? MODE_IDENT : idle_mode;
			MODE_NUMBER: mode_d = is_digit(c) ? MODE_NUMBER : idle_mode;
			MODE_STRING: mode_d = (c == CHAR_QUOTE || c == CHAR_NUL) ? MODE_IDLE : MODE_STRING;
			MODE_IDLE:   mode_d = idle_mode;
			default:     mode_d = MODE_IDLE;
		endcase
	end

	// Tokens caused by this byte.
	always_comb begin
		tok0  = idle_tok;
		tok1  = idle_tok;
		n_tok = {1'b0, idle_emit};
		case (mode_q)
			MODE_IDENT: begin
				if (alnum) begin
					n_tok = 2'd0;
				end else begin
					tok0  = '{kind: ident_kind(mask_q, len_q), start: start_q, length: len_q};
					n_tok = idle_emit ? 2'd2 : 2'd1;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(c)) begin
					n_tok = 2'd0;
				end else begin
					tok0  = '{kind: KIND_NUMBER, start: start_q, length: len_q};
					n_tok = idle_emit ? 2'd2 : 2'd1;
				end
			end
			MODE_STRING: begin
				if (c == CHAR_QUOTE) begin
					tok0  = '{kind: KIND_STRING, start: start_q, length: len_q};
					n_tok = 2'd1;
				end else if (c == CHAR_NUL) begin
					n_tok = 2'd1;
				end else begin
					n_tok = 2'd0;
				end
			end
			default: begin
				n_tok = {1'b0, idle_emit};
			end
		endcase
	end

	// Pending token data and position.
	always_comb begin
		start_d = start_q;
		len_d   = len_q;
		mask_d  = mask_q;
		case (mode_q)
			MODE_IDENT: begin
				if (alnum) begin
					mask_d = mask_q & kw_keep(c, len_q);
					len_d  = len_grow;
				end else begin
					start_d = idle_start;
					len_d   = idle_len;
					mask_d  = idle_mask;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(c)) begin
					len_d = len_grow;
				end else begin
					start_d = idle_start;
					len_d   = idle_len;
					mask_d  = idle_mask;
				end
			end
			MODE_STRING: begin
				if (c != CHAR_QUOTE && c != CHAR_NUL) begin
					len_d = len_grow;
				end
			end
			default: begin
				start_d = idle_start;
				len_d   = idle_len;
				mask_d  = idle_mask;
			end
		endcase
		if (c == CHAR_NUL) begin
			mask_d = '1;
			pos_d  = '0;
		end else begin
			pos_d = pos_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_IDLE;
			pos_q   <= '0;
			start_q <= '0;
			len_q   <= '0;
			mask_q  <= '1;
		end else if (acc) begin
			mode_q  <= mode_d;
			pos_q   <= pos_d;
			start_q <= start_d;
			len_q   <= len_d;
			mask_q  <= mask_d;
		end
	end

	assign push_valid = acc && (n_tok != 2'd0);
	assign push_entry = '{two: (n_tok == 2'd2), tok0: tok0, tok1: tok1};

	a_nul_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		acc && c == CHAR_NUL |=> pos_q == '0 && mode_q == MODE_IDLE && mask_q == '1)
		else $error("end of text did not restart the scanner");

endmodule
`default_nettype wire

### design/kt_queue.sv
`default_nettype none
module kt_queue import kt_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push_valid,
	input  entry_t push_entry,
	output logic   push_ready,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry
);

	localparam int PTR_BITS = $clog2(QUEUE_DEPTH);

	entry_t              mem_q [QUEUE_DEPTH];
	logic [PTR_BITS-1:0] wr_ptr_q, rd_ptr_q;
	logic [PTR_BITS:0]   count_q;
	logic                full, push;

	assign full       = (count_q == (PTR_BITS + 1)'(QUEUE_DEPTH));
	assign push_ready = !full;
	assign push       = push_valid && !full;
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (PTR_BITS + 1)'(push) - (PTR_BITS + 1)'(pop);
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (PTR_BITS + 1)'(QUEUE_DEPTH))
		else $error("queue holds more entries than its depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue popped while empty");

endmodule
`default_nettype wire

### design/kt_back.sv
`default_nettype none
module kt_back import kt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  entry_t     head_entry,
	output logic       pop,
	kt_token_if.source token
);

	logic   out_valid_q;
	token_t out_tok_q;
	logic   last_q;
	logic   sub_q;
	logic   load, first_of_two;

	assign load         = head_valid && (!out_valid_q || token.ready);
	assign first_of_two = head_entry.two && !sub_q;
	assign pop          = load && !first_of_two;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sub_q       <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				sub_q       <= first_of_two;
			end else if (token.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_tok_q <= sub_q ? head_entry.tok1 : head_entry.tok0;
			last_q    <= !first_of_two;
		end
	end

	assign token.valid        = out_valid_q;
	assign token.token_kind   = out_tok_q.kind;
	assign token.token_start  = out_tok_q.start;
	assign token.token_length = out_tok_q.length;
	assign token.last_of_item = last_q;

	a_pair_pending: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !last_q |-> sub_q && head_valid)
		else $error("first of a token pair shown without its second pending");

	a_second_after_first: assert property (@(posedge clk) disable iff (!arst_n)
		load && first_of_two |=> sub_q && !last_q)
		else $error("token pair split incorrectly");

endmodule
`default_nettype wire

### tb/tb_keyword_tokenizer.sv
`timescale 1ns / 100ps
module tb_keyword_tokenizer;
	import kt_pkg::*;

	// Stimulus sizes and run limits.
	localparam int RANDOM_BYTES = 1900;
	localparam int QUIET_TAIL = 300;
	localparam int SETTLE_CYCLES = 16;
	localparam longint CYCLE_LIMIT = 3000000;

	// One expected or observed token, with the flag that marks the last one of a byte.
	typedef struct packed {
		logic [KIND_BITS-1:0] kind;
		logic [15:0]          start;
		logic [LEN_BITS-1:0]  length;
		logic                 last;
	} token_rec_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// Values driven into the interfaces; the initializers keep every input known from time zero.
	logic       src_valid = 1'b0;
	logic [7:0] src_byte = 8'h00;
	logic       sink_ready = 1'b0;

	kt_byte_if  text_if();
	kt_token_if tok_bus();

	assign text_if.valid = src_valid;
	assign text_if.text_byte = src_byte;
	assign tok_bus.ready = sink_ready;

	keyword_tokenizer u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.text(text_if.sink),
		.token(tok_bus.source)
	);

	// Keyword spellings in kind order, and the eight symbol characters.
	string kw_words [KW_COUNT] = '{"let", "cprint", "add", "sub", "mul", "div", "if", "else",
		"equals", "string", "input", "true", "false", "bool", "func", "cend"};
	logic [7:0] sym_chars [SYM_COUNT] = '{"=", "(", ")", "{", "}", ";", "!", ":"};

	// Bytes still to be sent, and tokens the lexer is expected to produce, oldest first.
	logic [7:0] text_queue [$];
	token_rec_t token_expect [$];
	token_rec_t byte_tokens [$];

	// Mirror of the lexer state.
	mode_t               lex_mode = MODE_IDLE;
	logic [POS_BITS-1:0] lex_pos = '0;
	logic [15:0]         lex_start = '0;
	logic [LEN_BITS-1:0] lex_len = '0;
	logic [KW_COUNT-1:0] lex_mask = '1;

	logic       byte_taken = 1'b0;
	int         src_gap = 0;
	int         snk_gap = 0;
	int         idle_pct = 0;
	bit         quiet = 1'b0;
	longint     cycle_count = 0;
	int         errors = 0;
	token_rec_t seen;
	token_rec_t want;

	function automatic logic alpha(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
	endfunction

	function automatic logic numeral(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic blank(input logic [7:0] c);
		return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic int symbol_index(input logic [7:0] c);
		for (int s = 0; s < SYM_COUNT; s++) begin
			if (sym_chars[s] == c) begin
				return s;
			end
		end
		return -1;
	endfunction

	function automatic void add_token(input logic [KIND_BITS-1:0] kind, input logic [15:0] start,
		input logic [LEN_BITS-1:0] length);
		token_rec_t t;
		t.kind = kind;
		t.start = start;
		t.length = length;
		t.last = 1'b0;
		byte_tokens.push_back(t);
	endfunction

	// Drop every keyword that disagrees with character c at offset idx of the identifier.
	function automatic void narrow_keywords(input logic [7:0] c, input logic [LEN_BITS-1:0] idx);
		int i;
		i = int'(idx);
		for (int k = 0; k < KW_COUNT; k++) begin
			if (!(i < kw_words[k].len() && kw_words[k][i] == c)) begin
				lex_mask[k] = 1'b0;
			end
		end
	endfunction

	// The first keyword in kind order that still matches at the full length names the token.
	function automatic logic [KIND_BITS-1:0] word_kind();
		for (int k = 0; k < KW_COUNT; k++) begin
			if (lex_mask[k] && lex_len == kw_words[k].len()) begin
				return KIND_KW0 + KIND_BITS'(k);
			end
		end
		return KIND_IDENT;
	endfunction

	// Token lengths stop at the largest value instead of wrapping.
	function automatic void lengthen();
		if (lex_len != '1) begin
			lex_len = lex_len + 1'b1;
		end
	endfunction

	// What a byte does when no token is open.
	function automatic void scan_from_idle(input logic [7:0] c);
		int s;
		s = symbol_index(c);
		if (c == CHAR_NUL) begin
			add_token(KIND_END, lex_pos[15:0], '0);
		end else if (alpha(c)) begin
			lex_mode = MODE_IDENT;
			lex_start = lex_pos[15:0];
			lex_len = LEN_BITS'(1);
			lex_mask = '1;
			narrow_keywords(c, '0);
		end else if (numeral(c)) begin
			lex_mode = MODE_NUMBER;
			lex_start = lex_pos[15:0];
			lex_len = LEN_BITS'(1);
		end else if (c == CHAR_QUOTE) begin
			// The string text starts after the quote, at the wrapped next position.
			lex_mode = MODE_STRING;
			lex_start = 16'(POS_BITS'(lex_pos + 1'b1));
			lex_len = '0;
		end else if (s >= 0) begin
			add_token(KIND_SYM0 + KIND_BITS'(s), lex_pos[15:0], LEN_BITS'(1));
		end else if (!blank(c)) begin
			// An unknown byte gives an end token and scanning simply continues.
			add_token(KIND_END, lex_pos[15:0], '0);
		end
	endfunction

	// Advance the lexer mirror by one transferred byte and queue the tokens it causes.
	function automatic void lex_byte(input logic [7:0] c);
		token_rec_t t;
		byte_tokens.delete();
		case (lex_mode)
			MODE_IDENT: begin
				if (alpha(c) || numeral(c)) begin
					narrow_keywords(c, lex_len);
					lengthen();
				end else begin
					add_token(word_kind(), lex_start, lex_len);
					lex_mode = MODE_IDLE;
					scan_from_idle(c);
				end
			end
			MODE_NUMBER: begin
				if (numeral(c)) begin
					lengthen();
				end else begin
					add_token(KIND_NUMBER, lex_start, lex_len);
					lex_mode = MODE_IDLE;
					scan_from_idle(c);
				end
			end
			MODE_STRING: begin
				if (c == CHAR_QUOTE) begin
					add_token(KIND_STRING, lex_start, lex_len);
					lex_mode = MODE_IDLE;
				end else if (c == CHAR_NUL) begin
					// An unterminated string is dropped; only the end token comes out.
					lex_mode = MODE_IDLE;
					add_token(KIND_END, lex_pos[15:0], '0);
				end else begin
					lengthen();
				end
			end
			default: begin
				lex_mode = MODE_IDLE;
				scan_from_idle(c);
			end
		endcase
		// End of text restarts the position count.
		if (c == CHAR_NUL) begin
			lex_pos = '0;
			lex_mode = MODE_IDLE;
			lex_mask = '1;
		end else begin
			lex_pos = lex_pos + 1'b1;
		end
		if (byte_tokens.size() != 0) begin
			t = byte_tokens.pop_back();
			t.last = 1'b1;
			byte_tokens.push_back(t);
		end
		foreach (byte_tokens[i]) begin
			token_expect.push_back(byte_tokens[i]);
		end
	endfunction

	function automatic logic [7:0] rand_letter();
		int r;
		r = $urandom_range(0, 51);
		return (r < 26) ? 8'("a" + r) : 8'("A" + r - 26);
	endfunction

	function automatic logic [7:0] rand_alnum();
		int r;
		r = $urandom_range(0, 61);
		return (r < 52) ? rand_letter() : 8'("0" + r - 52);
	endfunction

	function automatic logic [7:0] rand_blank();
		int r;
		r = $urandom_range(0, 5);
		return (r == 5) ? 8'h20 : 8'(9 + r);
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			text_queue.push_back(s[i]);
		end
	endfunction

	// Hold until every byte has been sent and every expected token has come back.
	task automatic wait_drained();
		while (text_queue.size() != 0 || src_valid || token_expect.size() != 0) begin
			@(posedge clk);
		end
	endtask

	initial begin
		forever #1 clk = ~clk;
	end

	// Cycle count, the timeout, and a newly drawn idling rate at intervals, so that busy
	// stretches alternate with stretches that have no idling at all.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count % 200 == 0) begin
			case ($urandom_range(0, 3))
				0: idle_pct <= 0;
				1: idle_pct <= 5;
				2: idle_pct <= 20;
				default: idle_pct <= 40;
			endcase
		end
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("tb_keyword_tokenizer failed");
			$finish;
		end
	end

	// Byte sender: a byte stays offered until its transfer, then the next one follows,
	// sometimes after an idle burst.
	always @(negedge clk) begin
		if (arst_n) begin
			if (src_valid && !byte_taken) begin
				src_valid <= 1'b1;
			end else if (src_gap != 0) begin
				src_valid <= 1'b0;
				src_gap <= src_gap - 1;
			end else if (text_queue.size() != 0) begin
				if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
					src_valid <= 1'b0;
					src_gap <= $urandom_range(0, 5);
				end else begin
					src_valid <= 1'b1;
					src_byte <= text_queue.pop_front();
				end
			end else begin
				src_valid <= 1'b0;
			end
		end
	end

	// Token receiver: ready drops in idle bursts.
	always @(negedge clk) begin
		if (!arst_n) begin
			sink_ready <= 1'b0;
		end else if (snk_gap != 0) begin
			sink_ready <= 1'b0;
			snk_gap <= snk_gap - 1;
		end else if (!quiet && idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			sink_ready <= 1'b0;
			snk_gap <= $urandom_range(0, 5);
		end else begin
			sink_ready <= 1'b1;
		end
	end

	// Monitor: every byte transfer feeds the lexer mirror, every token transfer is checked
	// against the oldest expectation.
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_taken <= 1'b0;
		end else begin
			byte_taken <= src_valid && text_if.ready;
			if (src_valid && text_if.ready) begin
				lex_byte(src_byte);
			end
			if (tok_bus.valid && sink_ready) begin
				seen.kind = tok_bus.token_kind;
				seen.start = tok_bus.token_start;
				seen.length = tok_bus.token_length;
				seen.last = tok_bus.last_of_item;
				if (token_expect.size() == 0) begin
					errors++;
					$display("%0t: token with none expected:", $time,
						" kind %0d start %0d length %0d last %0d",
						seen.kind, seen.start, seen.length, seen.last);
				end else begin
					want = token_expect.pop_front();
					if (seen.kind !== want.kind || seen.start !== want.start ||
						seen.length !== want.length || seen.last !== want.last) begin
						errors++;
						$display("%0t: token mismatch:", $time,
							" expected kind %0d start %0d length %0d last %0d,",
							want.kind, want.start, want.length, want.last,
							" got kind %0d start %0d length %0d last %0d",
							seen.kind, seen.start, seen.length, seen.last);
					end
				end
			end
		end
	end

	initial begin
		int k;
		int n;
		logic [7:0] b;
		string w;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part: end of text while idle, a keyword and an identifier closed by symbols,
		// a number closed by a symbol, a string with a high byte, an empty string,
		// whitespace, an unknown byte, a keyword and a number cut off by end of text, and
		// an unterminated string.
		text_queue.push_back(CHAR_NUL);
		push_text("if(x9)7!");
		text_queue.push_back(CHAR_QUOTE);
		text_queue.push_back(8'h80);
		text_queue.push_back(CHAR_QUOTE);
		text_queue.push_back(CHAR_QUOTE);
		text_queue.push_back(CHAR_QUOTE);
		text_queue.push_back(8'h09);
		text_queue.push_back(8'h0D);
		text_queue.push_back(8'hFF);
		push_text("cend");
		text_queue.push_back(CHAR_NUL);
		push_text("5");
		text_queue.push_back(CHAR_NUL);
		text_queue.push_back(CHAR_QUOTE);
		push_text("q");
		text_queue.push_back(CHAR_NUL);

		// The sender pauses here until every token of the directed part has come.
		wait_drained();

		// Random part: mostly well-formed tokens with random content, sometimes run
		// together so that one byte closes a token and starts or gives another.
		while (text_queue.size() < RANDOM_BYTES) begin
			n = $urandom_range(0, 99);
			if (n < 30) begin
				// A keyword, sometimes one character too long, too short, or capitalized.
				w = kw_words[$urandom_range(0, KW_COUNT - 1)];
				case ($urandom_range(0, 7))
					0: begin
						push_text(w);
						text_queue.push_back(rand_alnum());
					end
					1: push_text(w.substr(0, w.len() - 2));
					2: begin
						text_queue.push_back(8'(w[0] - 8'h20));
						push_text(w.substr(1, w.len() - 1));
					end
					default: push_text(w);
				endcase
			end else if (n < 45) begin
				text_queue.push_back(rand_letter());
				k = $urandom_range(0, 7);
				for (int i = 0; i < k; i++) begin
					text_queue.push_back(rand_alnum());
				end
			end else if (n < 57) begin
				k = $urandom_range(1, 6);
				for (int i = 0; i < k; i++) begin
					text_queue.push_back(8'("0" + $urandom_range(0, 9)));
				end
			end else if (n < 67) begin
				text_queue.push_back(CHAR_QUOTE);
				k = $urandom_range(0, 6);
				for (int i = 0; i < k; i++) begin
					do begin
						b = 8'($urandom_range(1, 255));
					end while (b == CHAR_QUOTE);
					text_queue.push_back(b);
				end
				// A few strings are left open when the text ends.
				text_queue.push_back(($urandom_range(0, 9) == 0) ? CHAR_NUL : CHAR_QUOTE);
			end else if (n < 79) begin
				text_queue.push_back(sym_chars[$urandom_range(0, SYM_COUNT - 1)]);
			end else if (n < 85) begin
				do begin
					b = 8'($urandom_range(1, 255));
				end while (alpha(b) || numeral(b) || blank(b) || b == CHAR_QUOTE ||
					symbol_index(b) >= 0);
				text_queue.push_back(b);
			end else if (n < 90) begin
				text_queue.push_back(CHAR_NUL);
			end else begin
				k = $urandom_range(1, 3);
				for (int i = 0; i < k; i++) begin
					text_queue.push_back(rand_blank());
				end
			end
			if ($urandom_range(0, 9) < 6) begin
				text_queue.push_back(rand_blank());
			end
		end
		text_queue.push_back(CHAR_NUL);

		// The last stretch of the run goes without idling on either side.
		while (text_queue.size() > QUIET_TAIL) begin
			@(posedge clk);
		end
		quiet = 1'b1;

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("tb_keyword_tokenizer passed");
		end else begin
			$display("tb_keyword_tokenizer failed");
		end
		$finish;
	end

endmodule

### files.f
design/kt_pkg.sv
design/kt_byte_if.sv
design/kt_token_if.sv
design/kt_front.sv
design/kt_queue.sv
design/kt_back.sv
design/keyword_tokenizer.sv
tb/tb_keyword_tokenizer.sv
